FILE: rtl/min_heap_timer_queue_unit_macros.svh
// Assertion macros used by the timer queue checker
`ifndef MIN_HEAP_TIMER_QUEUE_UNIT_MACROS_SVH
`define MIN_HEAP_TIMER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MHTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MHTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mhtq_pkg.sv
// Types, codes and helper functions of the timer queue
`timescale 1ns / 1ps

package mhtq_pkg;

    localparam int TIME_W       = 48;
    localparam int RESULT_LIMIT = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_MODIFY = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    localparam logic [1:0] MODE_ONESHOT = 2'd0;
    localparam logic [1:0] MODE_CYCLIC  = 2'd1;
    localparam logic [1:0] MODE_LIMITED = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_EXP = 1'b1;

    localparam logic [1:0] REG_TICK_STEP = 2'd0;

    // decoded command word between front and engine
    typedef struct packed {
        t_op         op;
        logic [31:0] target_id;
        logic [31:0] interval;
        logic [1:0]  mode;
        logic [15:0] count;
    } t_cmd;

    // one heap slot
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [31:0]       interval;
        logic [1:0]        mode;
        logic [15:0]       remaining;
        logic [31:0]       ident;
    } t_entry;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // deadline order, ties to the lower id
    function automatic logic earlier(input t_entry a, input t_entry b);
        logic res;
        if (a.deadline != b.deadline) begin
            res = a.deadline < b.deadline;
        end else begin
            res = a.ident < b.ident;
        end
        return res;
    endfunction

endpackage

FILE: rtl/mhtq_if.sv
// Command and result channel interfaces of the timer queue
`timescale 1ns / 1ps

interface mhtq_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] target_id;
    logic [31:0] interval_ms;
    logic [1:0]  mode;
    logic [15:0] repeat_count;

    modport source (output valid, cmd, target_id, interval_ms, mode, repeat_count,
                    input ready);
    modport sink   (input valid, cmd, target_id, interval_ms, mode, repeat_count,
                    output ready);
endinterface

interface mhtq_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] id_out;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, kind, id_out, status, last, input ready);
    modport sink   (input valid, kind, id_out, status, last, output ready);
endinterface

FILE: rtl/min_heap_timer_queue_unit.sv
// Top level of the min-heap timer queue
// Add sifts the new slot into the heap before its acknowledge; clear resets the count;
//   remove/modify search the slots one by one, then sift the moved or changed slot.
// Tick: each due timer fired is rearmed and sifted down or erased, until none is due.
// The single-port heap sequencer handles one word at a time; its worst case is a tick
//   firing up to MAX_FIRE (at most RESULT_LIMIT) timers; a two-word queue takes words meanwhile.
// Reset (sync, active low): count, id counter, time, results cleared; heap slots not swept.
`timescale 1ns / 1ps

module min_heap_timer_queue_unit #(
    parameter int HEAP_DEPTH = 64,
    parameter int MAX_FIRE   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhtq_cmd_if.sink    i_cmd,
    mhtq_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // tick step register, the only config word
    logic [9:0]     r_tick_step;

    logic           q_full;
    logic           q_push;
    mhtq_pkg::t_cmd q_push_data;
    logic           q_valid;
    logic           q_pop;
    mhtq_pkg::t_cmd q_data;

    assign pready = 1'b1;
    assign prdata = (paddr == mhtq_pkg::REG_TICK_STEP) ? 32'(r_tick_step) : 32'd0;

    // one register only, so every write lands on it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= 10'd10;
        end else if (psel && penable && pwrite) begin
            r_tick_step <= pwdata[9:0];
        end
    end

    // front: accept and classify words
    mhtq_front u_front (
        .i_cmd       (i_cmd),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // decoupling queue
    mhtq_cmdq u_cmdq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_data      (q_data)
    );

    // back: heap engine with result register
    mhtq_engine #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .MAX_FIRE   (MAX_FIRE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_data    (q_data),
        .i_tick_step (r_tick_step),
        .o_res       (o_res)
    );

endmodule

FILE: rtl/mhtq_front.sv
// Front end: takes command words, drops unknown codes, normalises fields
`timescale 1ns / 1ps

module mhtq_front (
    mhtq_cmd_if.sink        i_cmd,
    input  logic            i_q_full,
    output logic            o_push,
    output mhtq_pkg::t_cmd  o_push_data
);

    logic known;

    assign i_cmd.ready = !i_q_full;
    assign known       = (i_cmd.cmd == mhtq_pkg::OP_TICK)   ||
                         (i_cmd.cmd == mhtq_pkg::OP_ADD)    ||
                         (i_cmd.cmd == mhtq_pkg::OP_REMOVE) ||
                         (i_cmd.cmd == mhtq_pkg::OP_MODIFY) ||
                         (i_cmd.cmd == mhtq_pkg::OP_CLEAR);
    assign o_push      = i_cmd.valid && !i_q_full && known;

    always_comb begin
        o_push_data.op        = mhtq_pkg::t_op'(i_cmd.cmd);
        o_push_data.target_id = i_cmd.target_id;
        // zero period runs as one ms
        o_push_data.interval  = (i_cmd.interval_ms == 32'd0) ? 32'd1 : i_cmd.interval_ms;
        // spare mode code runs as one-shot
        o_push_data.mode      = (i_cmd.mode == mhtq_pkg::MODE_SPARE) ? mhtq_pkg::MODE_ONESHOT
                                                                     : i_cmd.mode;
        o_push_data.count     = i_cmd.repeat_count;
    end

endmodule

FILE: rtl/mhtq_cmdq.sv
// Two-entry queue of decoded commands between front and engine
`timescale 1ns / 1ps

module mhtq_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mhtq_pkg::t_cmd  i_push_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output mhtq_pkg::t_cmd  o_data
);

    localparam int DEPTH = 2;

    mhtq_pkg::t_cmd r_mem [DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

FILE: rtl/mhtq_engine.sv
// Back end: heap store, id search, sift sequencer and result register
`timescale 1ns / 1ps

module mhtq_engine #(
    parameter int HEAP_DEPTH = 64,
    parameter int MAX_FIRE   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  mhtq_pkg::t_cmd  i_q_data,
    input  logic [9:0]      i_tick_step,
    mhtq_res_if.source      o_res
);

    localparam int IW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = IW + 2;
    localparam int FIRE_CAP = (MAX_FIRE < mhtq_pkg::RESULT_LIMIT) ? MAX_FIRE
                                                                  : mhtq_pkg::RESULT_LIMIT;
    localparam int NW = $clog2(FIRE_CAP + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ACK, S_F_RD, S_F_CMP, S_LAST, S_UP, S_UP_CMP,
        S_DN, S_DN_L, S_DN_R, S_T_RD, S_T_CHK, S_T_END
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [31:0]                   r_next_id, n_next_id;
    logic [mhtq_pkg::TIME_W-1:0]   r_time, n_time;
    mhtq_pkg::t_cmd                r_cmd, n_cmd;
    logic [CW-1:0]                 r_k, n_k;
    logic [IW-1:0]                 r_i, n_i;
    mhtq_pkg::t_entry              r_x, n_x;
    mhtq_pkg::t_entry              r_c, n_c;
    logic                          r_moved, n_moved;
    logic [NW-1:0]                 r_n, n_n;
    logic                          r_pend, n_pend;
    logic [31:0]                   r_pend_id, n_pend_id;
    logic [31:0]                   r_ack_id, n_ack_id;
    logic [1:0]                    r_ack_st, n_ack_st;
    logic                          r_ov, n_ov;
    logic                          r_okind, n_okind;
    logic [31:0]                   r_oid, n_oid;
    logic [1:0]                    r_ost, n_ost;
    logic                          r_olast, n_olast;

    mhtq_pkg::t_entry              r_mem [HEAP_DEPTH];
    mhtq_pkg::t_entry              r_rd;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    mhtq_pkg::t_entry              mem_wdata;
    logic                          mem_re;
    logic [IW-1:0]                 mem_raddr;

    logic                          out_free;
    t_state                        fin_state;
    logic [LW-1:0]                 lidx;
    logic [LW-1:0]                 ridx;
    logic [LW-1:0]                 cnt_l;
    logic [IW-1:0]                 parent;
    logic [CW-1:0]                 cnt_dec;
    logic [31:0]                   nid;
    logic                          sel_l;
    logic                          sel_r;
    logic                          rearm;
    mhtq_pkg::t_entry              best;

    assign out_free  = !r_ov || o_res.ready;
    assign fin_state = (r_cmd.op == mhtq_pkg::OP_TICK) ? S_T_RD : S_ACK;
    assign lidx      = {1'b0, r_i, 1'b1};
    assign ridx      = lidx + LW'(1);
    assign cnt_l     = LW'(r_cnt);
    assign parent    = IW'((r_i - IW'(1)) >> 1);
    assign cnt_dec   = r_cnt - CW'(1);
    assign nid       = (r_next_id == 32'hFFFF_FFFF) ? 32'd1 : r_next_id + 32'd1;
    assign sel_l     = mhtq_pkg::earlier(r_c, r_x);
    assign best      = sel_l ? r_c : r_x;
    assign sel_r     = mhtq_pkg::earlier(r_rd, best);
    assign rearm     = (r_rd.mode == mhtq_pkg::MODE_CYCLIC) ||
                       ((r_rd.mode == mhtq_pkg::MODE_LIMITED) && (r_rd.remaining > 16'd1));

    assign o_res.valid  = r_ov;
    assign o_res.kind   = r_okind;
    assign o_res.id_out = r_oid;
    assign o_res.status = r_ost;
    assign o_res.last   = r_olast;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_next_id = r_next_id;
        n_time    = r_time;
        n_cmd     = r_cmd;
        n_k       = r_k;
        n_i       = r_i;
        n_x       = r_x;
        n_c       = r_c;
        n_moved   = r_moved;
        n_n       = r_n;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_ack_id  = r_ack_id;
        n_ack_st  = r_ack_st;
        n_ov      = (r_ov && o_res.ready) ? 1'b0 : r_ov;
        n_okind   = r_okind;
        n_oid     = r_oid;
        n_ost     = r_ost;
        n_olast   = r_olast;
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_x;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    n_moved = 1'b0;
                    n_k     = '0;
                    unique case (i_q_data.op)
                        mhtq_pkg::OP_TICK: begin
                            n_time  = mhtq_pkg::sat_add(r_time,
                                                        mhtq_pkg::TIME_W'(i_tick_step));
                            n_n     = '0;
                            n_pend  = 1'b0;
                            n_state = S_T_RD;
                        end
                        mhtq_pkg::OP_ADD: begin
                            if (r_cnt == CW'(HEAP_DEPTH)) begin
                                n_ack_id = 32'd0;
                                n_ack_st = mhtq_pkg::ST_FULL;
                                n_state  = S_ACK;
                            end else begin
                                n_next_id     = nid;
                                n_x.deadline  = mhtq_pkg::sat_add(r_time,
                                                    mhtq_pkg::TIME_W'(i_q_data.interval));
                                n_x.interval  = i_q_data.interval;
                                n_x.mode      = i_q_data.mode;
                                n_x.remaining = i_q_data.count;
                                n_x.ident     = nid;
                                n_i           = r_cnt[IW-1:0];
                                n_cnt         = r_cnt + CW'(1);
                                n_ack_id      = nid;
                                n_ack_st      = mhtq_pkg::ST_OK;
                                n_state       = S_UP;
                            end
                        end
                        mhtq_pkg::OP_REMOVE, mhtq_pkg::OP_MODIFY: begin
                            n_state = S_F_RD;
                        end
                        mhtq_pkg::OP_CLEAR: begin
                            n_cnt    = '0;
                            n_ack_id = 32'd0;
                            n_ack_st = mhtq_pkg::ST_OK;
                            n_state  = S_ACK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_ACK: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = mhtq_pkg::KIND_ACK;
                    n_oid   = r_ack_id;
                    n_ost   = r_ack_st;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // linear id search: read a slot in S_F_RD, compare it in S_F_CMP
            S_F_RD: begin
                if (r_k == r_cnt) begin
                    n_ack_id = r_cmd.target_id;
                    n_ack_st = mhtq_pkg::ST_NOTFOUND;
                    n_state  = S_ACK;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k[IW-1:0];
                    n_state   = S_F_CMP;
                end
            end

            S_F_CMP: begin
                if (r_rd.ident == r_cmd.target_id) begin
                    n_ack_id = r_cmd.target_id;
                    n_ack_st = mhtq_pkg::ST_OK;
                    if (r_cmd.op == mhtq_pkg::OP_REMOVE) begin
                        n_cnt = cnt_dec;
                        if (r_k == cnt_dec) begin
                            n_state = fin_state;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = cnt_dec[IW-1:0];
                            n_state   = S_LAST;
                        end
                    end else begin
                        n_x.deadline  = mhtq_pkg::sat_add(r_time,
                                            mhtq_pkg::TIME_W'(r_cmd.interval));
                        n_x.interval  = r_cmd.interval;
                        n_x.mode      = r_cmd.mode;
                        n_x.remaining = r_cmd.count;
                        n_x.ident     = r_cmd.target_id;
                        n_i           = r_k[IW-1:0];
                        n_state       = S_UP;
                    end
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_F_RD;
                end
            end

            // tail slot moves into the hole left by an erase
            S_LAST: begin
                n_x     = r_rd;
                n_i     = r_k[IW-1:0];
                n_moved = 1'b0;
                n_state = S_UP;
            end

            S_UP: begin
                if (r_i == '0) begin
                    if (r_moved) begin
                        mem_we  = 1'b1;
                        n_state = fin_state;
                    end else begin
                        n_state = S_DN;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = parent;
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                if (mhtq_pkg::earlier(r_x, r_rd)) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd;
                    n_i       = parent;
                    n_moved   = 1'b1;
                    n_state   = S_UP;
                end else if (r_moved) begin
                    mem_we  = 1'b1;
                    n_state = fin_state;
                end else begin
                    n_state = S_DN;
                end
            end

            S_DN: begin
                if (lidx >= cnt_l) begin
                    mem_we  = 1'b1;
                    n_state = fin_state;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = lidx[IW-1:0];
                    n_state   = S_DN_L;
                end
            end

            S_DN_L: begin
                n_c = r_rd;
                if (ridx < cnt_l) begin
                    mem_re    = 1'b1;
                    mem_raddr = ridx[IW-1:0];
                    n_state   = S_DN_R;
                end else if (mhtq_pkg::earlier(r_rd, r_x)) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd;
                    n_i       = lidx[IW-1:0];
                    n_state   = S_DN;
                end else begin
                    mem_we  = 1'b1;
                    n_state = fin_state;
                end
            end

            S_DN_R: begin
                if (sel_r) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd;
                    n_i       = ridx[IW-1:0];
                    n_state   = S_DN;
                end else if (sel_l) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_c;
                    n_i       = lidx[IW-1:0];
                    n_state   = S_DN;
                end else begin
                    mem_we  = 1'b1;
                    n_state = fin_state;
                end
            end

            S_T_RD: begin
                if ((r_n == NW'(FIRE_CAP)) || (r_cnt == '0)) begin
                    n_state = S_T_END;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    n_state   = S_T_CHK;
                end
            end

            // root due: hand on the previous expiry, then rearm or erase
            S_T_CHK: begin
                if (r_rd.deadline <= r_time) begin
                    if (!r_pend || out_free) begin
                        if (r_pend) begin
                            n_ov    = 1'b1;
                            n_okind = mhtq_pkg::KIND_EXP;
                            n_oid   = r_pend_id;
                            n_ost   = mhtq_pkg::ST_OK;
                            n_olast = 1'b0;
                        end
                        n_pend    = 1'b1;
                        n_pend_id = r_rd.ident;
                        n_n       = r_n + NW'(1);
                        if (rearm) begin
                            n_x          = r_rd;
                            n_x.deadline = mhtq_pkg::sat_add(r_rd.deadline,
                                               mhtq_pkg::TIME_W'(r_rd.interval));
                            if (r_rd.mode == mhtq_pkg::MODE_LIMITED) begin
                                n_x.remaining = r_rd.remaining - 16'd1;
                            end
                            n_i     = '0;
                            n_moved = 1'b0;
                            n_state = S_DN;
                        end else begin
                            n_cnt = cnt_dec;
                            if (r_k == cnt_dec) begin
                                n_state = S_T_RD;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = cnt_dec[IW-1:0];
                                n_state   = S_LAST;
                            end
                        end
                    end
                end else begin
                    n_state = S_T_END;
                end
            end

            S_T_END: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = mhtq_pkg::KIND_EXP;
                    n_oid   = r_pend_id;
                    n_ost   = mhtq_pkg::ST_OK;
                    n_olast = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_next_id <= 32'd0;
            r_time    <= '0;
            r_pend    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_next_id <= n_next_id;
            r_time    <= n_time;
            r_pend    <= n_pend;
            r_ov      <= n_ov;
            r_cmd     <= n_cmd;
            r_k       <= n_k;
            r_i       <= n_i;
            r_x       <= n_x;
            r_c       <= n_c;
            r_moved   <= n_moved;
            r_n       <= n_n;
            r_pend_id <= n_pend_id;
            r_ack_id  <= n_ack_id;
            r_ack_st  <= n_ack_st;
            r_okind   <= n_okind;
            r_oid     <= n_oid;
            r_ost     <= n_ost;
            r_olast   <= n_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

endmodule

FILE: rtl/mhtq_checker.sv
// Port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
`include "min_heap_timer_queue_unit_macros.svh"

module mhtq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_kind,
    input logic [31:0] i_id_out,
    input logic [1:0]  i_status
);

    logic exp_v;
    logic full_v;

    assign exp_v  = i_valid && (i_kind == mhtq_pkg::KIND_EXP);
    assign full_v = i_valid && (i_status == mhtq_pkg::ST_FULL);

    `MHTQ_ASSERT_NEXT(a_hold, i_valid && !i_ready, i_valid, "result word dropped while stalled")
    `MHTQ_ASSERT_IMPL(a_exp_ok, exp_v, i_status == mhtq_pkg::ST_OK, "expiry with non-ok status")
    `MHTQ_ASSERT_IMPL(a_exp_id, exp_v, i_id_out != 32'd0, "expiry of id zero")
    `MHTQ_ASSERT_IMPL(a_full_id, full_v, i_id_out == 32'd0, "full add with nonzero id")

endmodule

bind min_heap_timer_queue_unit mhtq_checker u_mhtq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_kind   (o_res.kind),
    .i_id_out (o_res.id_out),
    .i_status (o_res.status)
);
